### rtl/core/sqt_pkg.sv
// sqt_pkg: shared widths, stage numbering and pipeline types for the sprite quad transform
// no dependencies; imported by every module under rtl/core
package sqt_pkg;

  // trig precision and table size
  localparam int TRIG_BITS        = 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int TRIG_W           = TRIG_BITS + 2;

  // angle in Q9.6 degrees, one full turn
  localparam int DEG_CIRCLE = 23040;
  localparam int ANG_W      = $clog2(DEG_CIRCLE);

  // table index = (angle * depth + half turn step) / full turn, by reciprocal
  localparam longint IDX_NUM_MAX = longint'(DEG_CIRCLE - 1) * SINE_TABLE_DEPTH
                                   + DEG_CIRCLE / 2;
  localparam int     NUM_W       = $clog2(IDX_NUM_MAX + 1);
  localparam longint RECIP       = (longint'(1) << NUM_W) / DEG_CIRCLE;
  localparam int     RECIP_W     = $clog2(RECIP + 1);

  // field widths
  localparam int IN_W   = 16;
  localparam int SCL_W  = 2 * IN_W;
  localparam int OUT_W  = 20;
  localparam int OUT_MAX = 524287;
  localparam int OUT_MIN = -524288;

  // datapath widths after rotation
  localparam int PROD_W = SCL_W + 1 + TRIG_W;
  localparam int SUM_W  = PROD_W + 3;
  localparam int RND_SH = 13 + TRIG_BITS;
  localparam int RND_W  = SUM_W - RND_SH;

  // pipeline stages
  localparam int NUM_STAGES = 8;
  localparam int ST_IN      = 1;
  localparam int ST_RECIP   = 2;
  localparam int ST_INDEX   = 3;
  localparam int ST_ROM     = 4;
  localparam int ST_TRIG    = 5;
  localparam int ST_MUL     = 6;
  localparam int ST_SUM     = 7;
  localparam int ST_OUT     = 8;

  typedef logic [NUM_STAGES:1] stage_en_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic [3:0][OUT_W-1:0] corner_vec_t;

  typedef struct packed {
    logic signed [IN_W-1:0] pos_x;
    logic signed [IN_W-1:0] pos_y;
    logic [SCL_W-1:0]       scl_w;
    logic [SCL_W-1:0]       scl_h;
    logic [1:0]             col;
    logic [1:0]             row;
  } geo_t;

endpackage

### rtl/core/sprite_quad_transform.sv
// sprite_quad_transform: top level, pivot register, pipeline control and geometry stages
// depends on sqt_pkg, sqt_angle_index, sqt_sine_rom, sqt_corner
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------------
//   cfg     | cfg_wr_en              | cfg_wr_data (pivot_position, 4 bit)
//   in      | in_valid / in_stall    | pos_x pos_y rect_width rect_height rotation_deg
//           |                        | scale_x scale_y
//   out     | out_valid / out_stall  | corner0_x .. corner3_y (20 bit signed Q16.4)
//
// eight-stage pipeline, one sprite per cycle while the output is not stalled
// the eight stages are: input/scale multiply, reciprocal multiply, index fix, rom read,
// quadrant sign, rotation multiply, edge sums, round/saturate (output register)
// rst is synchronous and clears the valid bits and the pivot register; no rom clearing needed
// each stage holds only when it is full and the stage after it holds, so bubbles get
// squeezed out and input keeps flowing while a result waits at the output
module sprite_quad_transform (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        rect_width,
  input  logic [15:0]        rect_height,
  input  logic signed [15:0] rotation_deg,
  input  logic [15:0]        scale_x,
  input  logic [15:0]        scale_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] corner0_x,
  output logic signed [19:0] corner0_y,
  output logic signed [19:0] corner1_x,
  output logic signed [19:0] corner1_y,
  output logic signed [19:0] corner2_x,
  output logic signed [19:0] corner2_y,
  output logic signed [19:0] corner3_x,
  output logic signed [19:0] corner3_y
);
  import sqt_pkg::*;

  logic [3:0]              pivot;
  logic [NUM_STAGES:1]     vld;
  stage_en_t               stage_en;
  logic [1:0]              piv_col;
  logic [1:0]              piv_row;
  geo_t                    geo_pipe [ST_IN:ST_TRIG];
  logic [IDX_W-1:0]        idx;
  trig_t                   sin_v;
  trig_t                   cos_v;
  corner_vec_t             corner_x;
  corner_vec_t             corner_y;

  // pivot register; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      pivot <= '0;
    end else if (cfg_wr_en) begin
      pivot <= cfg_wr_data;
    end
  end

  // stage enables: a stage loads when empty or when the next one moves on
  always_comb begin
    stage_en[NUM_STAGES] = !vld[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      stage_en[k] = !vld[k] || stage_en[k+1];
    end
  end

  assign in_stall  = !stage_en[ST_IN];
  assign out_valid = vld[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stage_en[ST_IN]) begin
        vld[ST_IN] <= in_valid;
      end
      for (int k = ST_IN + 1; k <= NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // pivot column and row; meaningless codes act as left-top
  always_comb begin
    unique case (pivot)
      4'd1:    begin piv_col = 2'd1; piv_row = 2'd0; end
      4'd2:    begin piv_col = 2'd2; piv_row = 2'd0; end
      4'd3:    begin piv_col = 2'd0; piv_row = 2'd1; end
      4'd4:    begin piv_col = 2'd1; piv_row = 2'd1; end
      4'd5:    begin piv_col = 2'd2; piv_row = 2'd1; end
      4'd6:    begin piv_col = 2'd0; piv_row = 2'd2; end
      4'd7:    begin piv_col = 2'd1; piv_row = 2'd2; end
      4'd8:    begin piv_col = 2'd2; piv_row = 2'd2; end
      default: begin piv_col = 2'd0; piv_row = 2'd0; end
    endcase
  end

  // stage 1: size times scale (exact Q.16 of the Q.4 size), then delay line to stage 5
  always_ff @(posedge clk) begin
    if (stage_en[ST_IN]) begin
      geo_pipe[ST_IN].pos_x <= pos_x;
      geo_pipe[ST_IN].pos_y <= pos_y;
      geo_pipe[ST_IN].scl_w <= SCL_W'(rect_width) * SCL_W'(scale_x);
      geo_pipe[ST_IN].scl_h <= SCL_W'(rect_height) * SCL_W'(scale_y);
      geo_pipe[ST_IN].col   <= piv_col;
      geo_pipe[ST_IN].row   <= piv_row;
    end
    for (int k = ST_IN + 1; k <= ST_TRIG; k++) begin
      if (stage_en[k]) begin
        geo_pipe[k] <= geo_pipe[k-1];
      end
    end
  end

  // stages 1..3: angle to table index
  sqt_angle_index u_angle (
    .clk          (clk),
    .stage_en     (stage_en),
    .rotation_deg (rotation_deg),
    .idx          (idx)
  );

  // stages 4..5: sine and cosine
  sqt_sine_rom u_rom (
    .clk      (clk),
    .stage_en (stage_en),
    .idx      (idx),
    .sin_v    (sin_v),
    .cos_v    (cos_v)
  );

  // stages 6..8: rotate, translate, round, clamp
  sqt_corner u_corner (
    .clk      (clk),
    .stage_en (stage_en),
    .geo      (geo_pipe[ST_TRIG]),
    .sin_v    (sin_v),
    .cos_v    (cos_v),
    .corner_x (corner_x),
    .corner_y (corner_y)
  );

  assign corner0_x = corner_x[0];
  assign corner0_y = corner_y[0];
  assign corner1_x = corner_x[1];
  assign corner1_y = corner_y[1];
  assign corner2_x = corner_x[2];
  assign corner2_y = corner_y[2];
  assign corner3_x = corner_x[3];
  assign corner3_y = corner_y[3];

  // checks
  logic in_xfer;
  logic flow;
  assign in_xfer = in_valid && !in_stall;
  assign flow    = !rst && !out_stall;

  // input only backs up when every stage is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while pipeline has room");

  // with the output flowing throughout, an accepted sprite must show up at out_valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ($past(in_xfer, 8) && $past(!rst, 8) && $past(flow, 1) && $past(flow, 2) &&
     $past(flow, 3) && $past(flow, 4) && $past(flow, 5) && $past(flow, 6) &&
     $past(flow, 7)) |-> out_valid)
    else $error("sprite lost in pipeline");

endmodule

### rtl/core/sqt_angle_index.sv
// sqt_angle_index: reduces the rotation modulo a full turn and maps it to a sine table index
// depends on sqt_pkg; three pipeline stages
module sqt_angle_index (
  input  logic                       clk,
  input  sqt_pkg::stage_en_t         stage_en,
  input  logic signed [15:0]         rotation_deg,
  output logic [sqt_pkg::IDX_W-1:0]  idx
);
  import sqt_pkg::*;

  localparam logic signed [ANG_W+2:0] DEG_S = (ANG_W + 3)'(DEG_CIRCLE);
  localparam int PW = NUM_W + RECIP_W;

  logic signed [ANG_W+2:0] rot_ext;
  logic [ANG_W-1:0]        ang;
  logic [NUM_W-1:0]        num_next;
  logic [NUM_W-1:0]        num1;
  logic [NUM_W-1:0]        num2;
  logic [PW-1:0]           prod;
  logic [IDX_W:0]          q_est;
  logic [NUM_W-1:0]        rem;
  logic [IDX_W:0]          q_fix;

  // stage 1: angle into [0, full turn), then scale to the numerator
  always_comb begin
    rot_ext = (ANG_W + 3)'(rotation_deg);
    priority if (rot_ext < -DEG_S) begin
      ang = ANG_W'(rot_ext + DEG_S + DEG_S);
    end else if (rot_ext < 0) begin
      ang = ANG_W'(rot_ext + DEG_S);
    end else if (rot_ext >= DEG_S) begin
      ang = ANG_W'(rot_ext - DEG_S);
    end else begin
      ang = ANG_W'(rot_ext);
    end
    num_next = NUM_W'({ang, IDX_W'(0)}) + NUM_W'(DEG_CIRCLE / 2);
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_IN]) begin
      num1 <= num_next;
    end
  end

  // stage 2: reciprocal multiply, estimate is exact or one low
  always_ff @(posedge clk) begin
    if (stage_en[ST_RECIP]) begin
      prod <= PW'(num1) * PW'(RECIP);
      num2 <= num1;
    end
  end

  // stage 3: one correction step; an index equal to the depth wraps to zero by truncation
  always_comb begin
    q_est = (IDX_W + 1)'(prod >> NUM_W);
    rem   = num2 - NUM_W'(q_est) * NUM_W'(DEG_CIRCLE);
    q_fix = q_est + (IDX_W + 1)'(rem >= NUM_W'(DEG_CIRCLE));
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_INDEX]) begin
      idx <= q_fix[IDX_W-1:0];
    end
  end

endmodule

### rtl/core/sqt_sine_rom.sv
// sqt_sine_rom: quarter-wave sine rom with registered reads and quadrant mirroring
// depends on sqt_pkg; rom contents are built at elaboration
module sqt_sine_rom (
  input  logic                      clk,
  input  sqt_pkg::stage_en_t        stage_en,
  input  logic [sqt_pkg::IDX_W-1:0] idx,
  output sqt_pkg::trig_t            sin_v,
  output sqt_pkg::trig_t            cos_v
);
  import sqt_pkg::*;

  localparam int QD     = SINE_TABLE_DEPTH / 4;
  localparam int QA_W   = IDX_W - 1;
  localparam int QV_W   = TRIG_BITS + 1;
  localparam int QROM_W = (QD + 1) * QV_W;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // entry m holds sin(pi/2 * m / QD), taylor series in Q30, rounded to Q.TRIG_BITS
  function automatic logic [QROM_W-1:0] build_qrom();
    logic [QROM_W-1:0] rom;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    longint            sum;
    longint            res;
    rom = '0;
    for (int m = 0; m <= QD; m++) begin
      x    = (PI_HALF_Q30 * 64'(4 * m)) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      res = (sum + (longint'(1) << (29 - TRIG_BITS))) >>> (30 - TRIG_BITS);
      if (res > (longint'(1) << TRIG_BITS)) begin
        res = longint'(1) << TRIG_BITS;
      end
      rom[m*QV_W +: QV_W] = QV_W'(res);
    end
    return rom;
  endfunction

  localparam logic [QROM_W-1:0] QROM = build_qrom();

  logic [QA_W-1:0] addr_a;
  logic [QA_W-1:0] addr_b;
  logic [QV_W-1:0] qa;
  logic [QV_W-1:0] qb;
  logic [1:0]      quad;
  trig_t           pa;
  trig_t           pb;

  always_comb begin
    addr_a = {1'b0, idx[IDX_W-3:0]};
    addr_b = QA_W'(QD) - addr_a;
  end

  // stage 4: two rom reads, direct and mirrored
  always_ff @(posedge clk) begin
    if (stage_en[ST_ROM]) begin
      qa   <= QROM[addr_a*QV_W +: QV_W];
      qb   <= QROM[addr_b*QV_W +: QV_W];
      quad <= idx[IDX_W-1:IDX_W-2];
    end
  end

  // stage 5: quadrant signs
  always_comb begin
    pa = trig_t'({1'b0, qa});
    pb = trig_t'({1'b0, qb});
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_TRIG]) begin
      unique case (quad)
        2'd0: begin
          sin_v <= pa;
          cos_v <= pb;
        end
        2'd1: begin
          sin_v <= pb;
          cos_v <= -pa;
        end
        2'd2: begin
          sin_v <= -pa;
          cos_v <= -pb;
        end
        default: begin
          sin_v <= -pb;
          cos_v <= pa;
        end
      endcase
    end
  end

endmodule

### rtl/core/sqt_corner.sv
// sqt_corner: rotation products, per-corner sums, rounding and saturation of the quad corners
// depends on sqt_pkg; three pipeline stages, last one is the output register
module sqt_corner (
  input  logic                 clk,
  input  sqt_pkg::stage_en_t   stage_en,
  input  sqt_pkg::geo_t        geo,
  input  sqt_pkg::trig_t       sin_v,
  input  sqt_pkg::trig_t       cos_v,
  output sqt_pkg::corner_vec_t corner_x,
  output sqt_pkg::corner_vec_t corner_y
);
  import sqt_pkg::*;

  // corner order: top-left, top-right, bottom-right, bottom-left
  localparam logic [3:0] RIGHT_SIDE  = 4'b0110;
  localparam logic [3:0] BOTTOM_SIDE = 4'b1100;
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(OUT_MAX);
  localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(OUT_MIN);

  // weight 0..2 times v, optionally negated
  function automatic logic signed [SUM_W-1:0] scaled(logic signed [PROD_W-1:0] v,
                                                     logic [1:0] wgt, logic neg);
    logic signed [SUM_W-1:0] ve;
    logic signed [SUM_W-1:0] t;
    ve = SUM_W'(v);
    unique case (wgt)
      2'd1:    t = ve;
      2'd2:    t = ve <<< 1;
      default: t = '0;
    endcase
    return neg ? -t : t;
  endfunction

  // position aligned to the product scale, rounding half folded in
  function automatic logic signed [SUM_W-1:0] pos_bias(logic signed [IN_W-1:0] p);
    return $signed({{(SUM_W - RND_SH - IN_W){p[IN_W-1]}}, p, 1'b1, (RND_SH - 1)'(0)});
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(logic signed [RND_W-1:0] v);
    logic [OUT_W-1:0] r;
    priority if (v > SAT_HI) begin
      r = OUT_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = OUT_W'(SAT_LO);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

  logic signed [PROD_W-1:0] ac;
  logic signed [PROD_W-1:0] as_p;
  logic signed [PROD_W-1:0] bc;
  logic signed [PROD_W-1:0] bs;
  geo_t                     geo6;
  logic signed [SUM_W-1:0]  xl;
  logic signed [SUM_W-1:0]  xr;
  logic signed [SUM_W-1:0]  xt;
  logic signed [SUM_W-1:0]  xb;
  logic signed [SUM_W-1:0]  yl;
  logic signed [SUM_W-1:0]  yr;
  logic signed [SUM_W-1:0]  yt;
  logic signed [SUM_W-1:0]  yb;
  logic signed [SUM_W-1:0]  dx [4];
  logic signed [SUM_W-1:0]  dy [4];
  logic signed [RND_W-1:0]  rx [4];
  logic signed [RND_W-1:0]  ry [4];

  // stage 6: scaled size times sine and cosine
  always_ff @(posedge clk) begin
    if (stage_en[ST_MUL]) begin
      ac   <= $signed({1'b0, geo.scl_w}) * cos_v;
      as_p <= $signed({1'b0, geo.scl_w}) * sin_v;
      bc   <= $signed({1'b0, geo.scl_h}) * cos_v;
      bs   <= $signed({1'b0, geo.scl_h}) * sin_v;
      geo6 <= geo;
    end
  end

  // stage 7: pivot weights per edge; left edge -col, right edge 2-col, same for rows
  always_ff @(posedge clk) begin
    if (stage_en[ST_SUM]) begin
      xl <= scaled(ac, geo6.col, 1'b1) + pos_bias(geo6.pos_x);
      xr <= scaled(ac, 2'd2 - geo6.col, 1'b0) + pos_bias(geo6.pos_x);
      xt <= scaled(bs, geo6.row, 1'b1);
      xb <= scaled(bs, 2'd2 - geo6.row, 1'b0);
      yl <= scaled(as_p, geo6.col, 1'b1) + pos_bias(geo6.pos_y);
      yr <= scaled(as_p, 2'd2 - geo6.col, 1'b0) + pos_bias(geo6.pos_y);
      yt <= scaled(bc, geo6.row, 1'b1);
      yb <= scaled(bc, 2'd2 - geo6.row, 1'b0);
    end
  end

  // stage 8: combine edges, drop fraction (ties already biased up), clamp
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dx[i] = (RIGHT_SIDE[i] ? xr : xl) - (BOTTOM_SIDE[i] ? xb : xt);
      dy[i] = (RIGHT_SIDE[i] ? yr : yl) + (BOTTOM_SIDE[i] ? yb : yt);
      rx[i] = RND_W'(dx[i] >>> RND_SH);
      ry[i] = RND_W'(dy[i] >>> RND_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_OUT]) begin
      for (int i = 0; i < 4; i++) begin
        corner_x[i] <= sat_out(rx[i]);
        corner_y[i] <= sat_out(ry[i]);
      end
    end
  end

endmodule
